>>> sv/rc_pulse_door_servo_sequencer_unit_defines.svh
// ---------------------------------------------------------------------------
// rc pulse door servo sequencer assertion macros
// shared concurrent assertion forms for the sequencer unit
// ---------------------------------------------------------------------------
`ifndef RC_PULSE_DOOR_SERVO_SEQUENCER_UNIT_DEFINES_SVH
`define RC_PULSE_DOOR_SERVO_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RCPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RCPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rcps_pkg.sv
// ---------------------------------------------------------------------------
// rcps_pkg
// types and constants shared by the rc pulse door servo sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package rcps_pkg;

  localparam int unsigned S_TDATA_W   = 16;
  localparam int unsigned M_TDATA_W   = 24;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned WAIT_W      = 9;
  localparam int unsigned PADDR_W     = 5;

  localparam logic [WAIT_W-1:0] KEY_STEP_MS  = 9'd30;
  localparam logic [WAIT_W-1:0] DOOR_STEP_MS = 9'd22;
  localparam logic [WAIT_W-1:0] PAUSE_MS     = 9'd400;
  localparam logic [WAIT_W-1:0] SETTLE_MS    = 9'd100;

  localparam logic [7:0] RST_PULSE_MIN       = 8'd56;
  localparam logic [7:0] RST_PULSE_MAX       = 8'd112;
  localparam logic [7:0] RST_OPEN_THRESHOLD  = 8'd84;
  localparam logic [7:0] RST_KEY_OPEN_POS    = 8'd59;
  localparam logic [7:0] RST_KEY_CLOSED_POS  = 8'd109;
  localparam logic [7:0] RST_DOOR_OPEN_POS   = 8'd52;
  localparam logic [7:0] RST_DOOR_CLOSED_POS = 8'd123;
  localparam logic [7:0] RST_DOOR_REST_POS   = 8'd114;
  localparam logic [7:0] RST_FILTERED_WIDTH  = 8'd56;

  // item kinds decided by the front end
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_WIDTH = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_KEY_OPENING  = 3'd1,
    PH_PAUSE_OPEN   = 3'd2,
    PH_DOOR_OPENING = 3'd3,
    PH_DOOR_CLOSING = 3'd4,
    PH_PAUSE_CLOSE  = 3'd5,
    PH_KEY_CLOSING  = 3'd6,
    PH_SETTLE       = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    REG_PULSE_MIN       = 3'd0,
    REG_PULSE_MAX       = 3'd1,
    REG_OPEN_THRESHOLD  = 3'd2,
    REG_KEY_OPEN_POS    = 3'd3,
    REG_KEY_CLOSED_POS  = 3'd4,
    REG_DOOR_OPEN_POS   = 3'd5,
    REG_DOOR_CLOSED_POS = 3'd6,
    REG_DOOR_REST_POS   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] width;
  } item_t;

  typedef struct packed {
    logic [7:0] pulse_min;
    logic [7:0] pulse_max;
    logic [7:0] open_threshold;
    logic [7:0] key_open_pos;
    logic [7:0] key_closed_pos;
    logic [7:0] door_open_pos;
    logic [7:0] door_closed_pos;
    logic [7:0] door_rest_pos;
  } cfg_t;

  typedef struct packed {
    phase_e phase;
    logic   door_open;
  } status_t;

endpackage

`default_nettype wire

>>> sv/rcps_front.sv
// ---------------------------------------------------------------------------
// rcps_front
// accepts stream items, measures pulse widths and pushes classified work
// ---------------------------------------------------------------------------
`default_nettype none

module rcps_front import rcps_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire logic [S_TDATA_W-1:0] s_data_i,
  input  wire logic                 s_user_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output item_t                     item_o
);

  logic [7:0] start_count_q, start_count_d;
  logic       pin_level;
  logic [7:0] timer_count;

  assign pin_level   = s_data_i[0];
  assign timer_count = s_data_i[8:1];
  assign s_ready_o   = !q_full_i;
  assign push_o      = s_valid_i && !q_full_i;

  always_comb begin
    start_count_d = start_count_q;
    item_o.width  = timer_count - start_count_q;
    if (s_user_i) begin
      item_o.kind = KIND_TICK;
    end else if (!pin_level) begin
      item_o.kind = KIND_START;
      if (push_o) begin
        start_count_d = timer_count;
      end
    end else begin
      item_o.kind = KIND_WIDTH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_count_q <= 8'd0;
    end else begin
      start_count_q <= start_count_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/rcps_queue.sv
// ---------------------------------------------------------------------------
// rcps_queue
// short fifo of classified items between front and back end
// ---------------------------------------------------------------------------
`default_nettype none

module rcps_queue import rcps_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      push_item_i,
  input  wire logic  pop_i,
  output item_t      pop_item_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/rcps_back.sv
// ---------------------------------------------------------------------------
// rcps_back
// width filter, servo sequencer and output register
// ---------------------------------------------------------------------------
`default_nettype none

module rcps_back import rcps_pkg::*; #(
  parameter int unsigned FILTER_SHIFT = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  cfg_t                      cfg_i,
  input  wire logic                 q_empty_i,
  input  item_t                     item_i,
  output logic                      pop_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output logic [M_TDATA_W-1:0]      m_data_o,
  output status_t                   status_o
);

  localparam int unsigned ACC_W = 8 + FILTER_SHIFT + 1;

  logic [7:0]        fw_q, fw_d;
  logic              req_q, req_d;
  logic              pad_q, pad_d;
  logic              open_q, open_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        ramp_q, ramp_d;
  logic [WAIT_W-1:0] wait_q, wait_d, wait_dec;
  logic [7:0]        key_q, key_d;
  logic [7:0]        door_q, door_d;
  logic              out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [ACC_W-1:0]  acc;
  logic [7:0]        filt;

  assign pop_o     = !q_empty_i && (!out_valid_q || m_ready_i);
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign status_o  = '{phase: phase_q, door_open: open_q};

  // mean update: (old * (2^s - 1) + width) >> s
  assign acc  = {1'b0, fw_q, {FILTER_SHIFT{1'b0}}} - ACC_W'(fw_q) + ACC_W'(item_i.width);
  assign filt = acc[FILTER_SHIFT +: 8];
  assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : wait_q;

  always_comb begin
    fw_d    = fw_q;
    req_d   = req_q;
    pad_d   = pad_q;
    open_d  = open_q;
    phase_d = phase_q;
    ramp_d  = ramp_q;
    wait_d  = wait_q;
    key_d   = key_q;
    door_d  = door_q;
    if (pop_o) begin
      case (item_i.kind)
        KIND_WIDTH: begin
          if (item_i.width >= cfg_i.pulse_min && item_i.width <= cfg_i.pulse_max) begin
            fw_d  = filt;
            req_d = (filt > cfg_i.open_threshold);
            pad_d = !(filt > cfg_i.open_threshold);
          end
        end
        KIND_TICK: begin
          if (phase_q == PH_IDLE) begin
            if (req_q && !open_q) begin
              if (cfg_i.key_closed_pos >= cfg_i.key_open_pos) begin
                ramp_d  = cfg_i.key_closed_pos;
                key_d   = cfg_i.key_closed_pos;
                wait_d  = KEY_STEP_MS;
                phase_d = PH_KEY_OPENING;
              end else begin
                wait_d  = PAUSE_MS;
                phase_d = PH_PAUSE_OPEN;
              end
            end else if (!req_q && open_q) begin
              if (cfg_i.door_open_pos <= cfg_i.door_closed_pos) begin
                ramp_d  = cfg_i.door_open_pos;
                door_d  = cfg_i.door_open_pos;
                wait_d  = DOOR_STEP_MS;
                phase_d = PH_DOOR_CLOSING;
              end else begin
                wait_d  = PAUSE_MS;
                phase_d = PH_PAUSE_CLOSE;
              end
            end
          end else begin
            wait_d = wait_dec;
            if (wait_dec == '0) begin
              unique case (phase_q)
                PH_KEY_OPENING: begin
                  if (ramp_q > cfg_i.key_open_pos) begin
                    ramp_d = ramp_q - 1'b1;
                    key_d  = ramp_q - 1'b1;
                    wait_d = KEY_STEP_MS;
                  end else begin
                    wait_d  = PAUSE_MS;
                    phase_d = PH_PAUSE_OPEN;
                  end
                end
                PH_PAUSE_OPEN: begin
                  if (cfg_i.door_rest_pos >= cfg_i.door_open_pos) begin
                    ramp_d  = cfg_i.door_rest_pos;
                    door_d  = cfg_i.door_rest_pos;
                    wait_d  = DOOR_STEP_MS;
                    phase_d = PH_DOOR_OPENING;
                  end else begin
                    open_d  = 1'b1;
                    phase_d = PH_IDLE;
                  end
                end
                PH_DOOR_OPENING: begin
                  if (ramp_q > cfg_i.door_open_pos) begin
                    ramp_d = ramp_q - 1'b1;
                    door_d = ramp_q - 1'b1;
                    wait_d = DOOR_STEP_MS;
                  end else begin
                    open_d  = 1'b1;
                    phase_d = PH_IDLE;
                  end
                end
                PH_DOOR_CLOSING: begin
                  if (ramp_q < cfg_i.door_closed_pos) begin
                    ramp_d = ramp_q + 1'b1;
                    door_d = ramp_q + 1'b1;
                    wait_d = DOOR_STEP_MS;
                  end else begin
                    wait_d  = PAUSE_MS;
                    phase_d = PH_PAUSE_CLOSE;
                  end
                end
                PH_PAUSE_CLOSE: begin
                  if (cfg_i.key_open_pos <= cfg_i.key_closed_pos) begin
                    ramp_d  = cfg_i.key_open_pos;
                    key_d   = cfg_i.key_open_pos;
                    wait_d  = KEY_STEP_MS;
                    phase_d = PH_KEY_CLOSING;
                  end else begin
                    wait_d  = SETTLE_MS;
                    phase_d = PH_SETTLE;
                  end
                end
                PH_KEY_CLOSING: begin
                  if (ramp_q < cfg_i.key_closed_pos) begin
                    ramp_d = ramp_q + 1'b1;
                    key_d  = ramp_q + 1'b1;
                    wait_d = KEY_STEP_MS;
                  end else begin
                    wait_d  = SETTLE_MS;
                    phase_d = PH_SETTLE;
                  end
                end
                PH_SETTLE: begin
                  door_d  = cfg_i.door_rest_pos;
                  open_d  = 1'b0;
                  phase_d = PH_IDLE;
                end
                default: begin
                  phase_d = PH_IDLE;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= RST_FILTERED_WIDTH;
      req_q       <= 1'b0;
      pad_q       <= 1'b0;
      open_q      <= 1'b0;
      phase_q     <= PH_IDLE;
      ramp_q      <= 8'd0;
      wait_q      <= '0;
      key_q       <= RST_KEY_CLOSED_POS;
      door_q      <= RST_DOOR_REST_POS;
      out_valid_q <= 1'b0;
    end else begin
      fw_q    <= fw_d;
      req_q   <= req_d;
      pad_q   <= pad_d;
      open_q  <= open_d;
      phase_q <= phase_d;
      ramp_q  <= ramp_d;
      wait_q  <= wait_d;
      key_q   <= key_d;
      door_q  <= door_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= {5'd0, (phase_d != PH_IDLE), open_d, pad_d,
                     8'd255 - door_d, 8'd255 - key_d};
    end
  end

endmodule

`default_nettype wire

>>> sv/rc_pulse_door_servo_sequencer_unit.sv
// ---------------------------------------------------------------------------
// rc_pulse_door_servo_sequencer_unit
// rc pulse width decoder driving a key and door servo sequencer
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one transaction per event: tuser is the mode (0 pin edge,
//   1 millisecond tick), tdata holds the pin level and the 8-bit timer count.
//   m_axis returns exactly one transaction per input transaction with the
//   two servo compare values, the test pad, the door state and busy flag.
//   the apb port holds eight 8-bit setup registers at byte address 4*i;
//   write them only while no transaction is in flight.
// throughput:
//   a transaction passes the front end into a two-entry queue, the back end
//   pops it and registers the result; one transaction per cycle is
//   sustained while m_axis_tready stays high, and each popped item is
//   handled combinationally in the back end before the result register.
// reset:
//   all control state returns to the closed, idle door with default registers.
// stall:
//   while m_axis_tready is low the output register holds, the queue fills
//   and s_axis_tready drops once both queue entries are taken.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rc_pulse_door_servo_sequencer_unit_defines.svh"

module rc_pulse_door_servo_sequencer_unit import rcps_pkg::*; #(
  parameter int unsigned FILTER_SHIFT = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [0] pin_level, [8:1] timer_count
  input  wire logic                 s_axis_tuser,  // [0] mode
  // result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [7:0] key_compare, [15:8] door_compare, [16] test_pad, [17] door_state,
  // [18] busy_res
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  logic     push, pop, q_full, q_empty;
  item_t    push_item, pop_item;
  status_t  status;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_PULSE_MIN:       prdata = {24'd0, cfg_q.pulse_min};
      REG_PULSE_MAX:       prdata = {24'd0, cfg_q.pulse_max};
      REG_OPEN_THRESHOLD:  prdata = {24'd0, cfg_q.open_threshold};
      REG_KEY_OPEN_POS:    prdata = {24'd0, cfg_q.key_open_pos};
      REG_KEY_CLOSED_POS:  prdata = {24'd0, cfg_q.key_closed_pos};
      REG_DOOR_OPEN_POS:   prdata = {24'd0, cfg_q.door_open_pos};
      REG_DOOR_CLOSED_POS: prdata = {24'd0, cfg_q.door_closed_pos};
      REG_DOOR_REST_POS:   prdata = {24'd0, cfg_q.door_rest_pos};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min       <= RST_PULSE_MIN;
      cfg_q.pulse_max       <= RST_PULSE_MAX;
      cfg_q.open_threshold  <= RST_OPEN_THRESHOLD;
      cfg_q.key_open_pos    <= RST_KEY_OPEN_POS;
      cfg_q.key_closed_pos  <= RST_KEY_CLOSED_POS;
      cfg_q.door_open_pos   <= RST_DOOR_OPEN_POS;
      cfg_q.door_closed_pos <= RST_DOOR_CLOSED_POS;
      cfg_q.door_rest_pos   <= RST_DOOR_REST_POS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PULSE_MIN:       cfg_q.pulse_min       <= pwdata[7:0];
        REG_PULSE_MAX:       cfg_q.pulse_max       <= pwdata[7:0];
        REG_OPEN_THRESHOLD:  cfg_q.open_threshold  <= pwdata[7:0];
        REG_KEY_OPEN_POS:    cfg_q.key_open_pos    <= pwdata[7:0];
        REG_KEY_CLOSED_POS:  cfg_q.key_closed_pos  <= pwdata[7:0];
        REG_DOOR_OPEN_POS:   cfg_q.door_open_pos   <= pwdata[7:0];
        REG_DOOR_CLOSED_POS: cfg_q.door_closed_pos <= pwdata[7:0];
        REG_DOOR_REST_POS:   cfg_q.door_rest_pos   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // front end: edge timing and classification
  rcps_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .q_full_i  (q_full),
    .push_o    (push),
    .item_o    (push_item)
  );

  // decoupling queue
  rcps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // back end: filter, sequencer, result register
  rcps_back #(
    .FILTER_SHIFT (FILTER_SHIFT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .item_i    (pop_item),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .status_o  (status)
  );

  // checks
  `RCPS_ASSERT_NOW(a_busy_matches_phase, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[18] == (status.phase != PH_IDLE), "busy flag disagrees with sequencer phase")
  `RCPS_ASSERT_NOW(a_door_matches_state, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[17] == status.door_open, "door state disagrees with sequencer")
  `RCPS_ASSERT_NEXT(a_back_drains_queue, clk_i, rst_ni, !q_empty && !m_axis_tvalid, m_axis_tvalid, "back end left a queued item waiting")
  `RCPS_ASSERT_NOW(a_no_accept_when_full, clk_i, rst_ni, q_full, !s_axis_tready, "input accepted into a full queue")

endmodule

`default_nettype wire
